@@ rtl/rcrs_pkg.sv @@
// Shared constants and fixed-point widths of the column ray setup block.
package rcrs_pkg;

  // Base formats.
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned COLUMN_BITS = 12;
  localparam int unsigned POS_BITS    = FRAC_BITS + 8;
  localparam int unsigned DIR_BITS    = FRAC_BITS + 2;
  localparam int unsigned DIST_BITS   = FRAC_BITS + 16;
  localparam int unsigned CELL_BITS   = 8;

  // Intermediate widths: column numerator and plane product.
  localparam int unsigned NUM_W  = COLUMN_BITS + 2;
  localparam int unsigned PROD_W = DIR_BITS + NUM_W;

  // Divider widths cover both the ray division and the distance divisions.
  localparam int unsigned DIV_NW =
      (2 * FRAC_BITS + 1 > DIR_BITS + COLUMN_BITS + 1) ? 2 * FRAC_BITS + 1
                                                       : DIR_BITS + COLUMN_BITS + 1;
  localparam int unsigned DIV_DW = (COLUMN_BITS > DIR_BITS) ? COLUMN_BITS : DIR_BITS;
  localparam int unsigned QEXT_W = (DIV_NW > DIST_BITS) ? DIV_NW : DIST_BITS;

  // Pipeline depth from input register to output register.
  localparam int unsigned LAT = 2 * DIV_NW + 6;

  // Register map.
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;
  localparam logic [2:0] REG_WIDTH   = 3'd6;

  // Grid step codes.
  localparam logic signed [1:0] STEP_POS = 2'sb01;
  localparam logic signed [1:0] STEP_NEG = 2'sb11;

endpackage

@@ rtl/rcrs_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
module rcrs_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [rcrs_pkg::DIV_NW-1:0] num_i,
  input  logic [rcrs_pkg::DIV_DW-1:0] den_i,
  output logic [rcrs_pkg::DIV_NW-1:0] quo_o
);

  localparam int unsigned NW = rcrs_pkg::DIV_NW;
  localparam int unsigned DW = rcrs_pkg::DIV_DW;

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] num_in;
    logic [NW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    // Shift in the next numerator bit and subtract the divisor where it fits.
    assign trial = {rem_in, num_in[NW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        num_q[k] <= {num_in[NW-2:0], 1'b0};
        quo_q[k] <= {quo_in[NW-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[NW-1];

endmodule

@@ rtl/raycast_column_ray_setup.sv @@
// Top level of the column ray setup pipeline with its APB register file.
//
// Usage: the camera (position, view direction, plane, screen width) is
// written over the APB port while no transaction is in flight. Each input
// transaction carries one screen column; each output transaction carries
// the ray direction, start cell, grid steps, delta distances and initial
// side distances for that column, in the order the columns were taken.
// Depth: the pipeline depth is set by two chains of one-bit-per-stage
// dividers: the column scaling by the screen width, and then the
// reciprocal and side distance divisions.
// Throughput: one column per cycle while the output is not stalled.
// Stalls: the whole pipeline holds while a result waits at the output
// register; in_ready_o then drops and nothing is lost or repeated.
// Reset: the pipeline empties and the registers take their reset values
// (view along +x, plane of about 0.66 along +y, 640 columns).
module raycast_column_ray_setup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rcrs_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // Column input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rcrs_pkg::COLUMN_BITS-1:0]    column_i,
  // Ray result output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rcrs_pkg::DIR_BITS-1:0] ray_x_o,
  output logic signed [rcrs_pkg::DIR_BITS-1:0] ray_y_o,
  output logic [rcrs_pkg::CELL_BITS-1:0]      cell_x_o,
  output logic [rcrs_pkg::CELL_BITS-1:0]      cell_y_o,
  output logic signed [1:0]                   step_dir_x_o,
  output logic signed [1:0]                   step_dir_y_o,
  output logic [rcrs_pkg::DIST_BITS-1:0]      delta_x_o,
  output logic [rcrs_pkg::DIST_BITS-1:0]      delta_y_o,
  output logic [rcrs_pkg::DIST_BITS-1:0]      side_x_o,
  output logic [rcrs_pkg::DIST_BITS-1:0]      side_y_o
);

  localparam int unsigned F     = rcrs_pkg::FRAC_BITS;
  localparam int unsigned CB    = rcrs_pkg::COLUMN_BITS;
  localparam int unsigned PB    = rcrs_pkg::POS_BITS;
  localparam int unsigned DB    = rcrs_pkg::DIR_BITS;
  localparam int unsigned XB    = rcrs_pkg::DIST_BITS;
  localparam int unsigned NUMW  = rcrs_pkg::NUM_W;
  localparam int unsigned PRODW = rcrs_pkg::PROD_W;
  localparam int unsigned DNW   = rcrs_pkg::DIV_NW;
  localparam int unsigned DDW   = rcrs_pkg::DIV_DW;
  localparam int unsigned QEW   = rcrs_pkg::QEXT_W;
  localparam int unsigned LAT   = rcrs_pkg::LAT;
  localparam int unsigned SUMW  = DNW + 2;

  localparam logic [DB-1:0] DIR_X_RST   = DB'(1 << F);
  localparam logic [DB-1:0] PLANE_Y_RST = DB'((64'd43254 << F) >> 16);
  localparam logic [CB-1:0] WIDTH_RST   = CB'(640);

  localparam logic signed [SUMW-1:0] RAY_MAX = SUMW'((2 ** (DB - 1)) - 1);
  localparam logic signed [SUMW-1:0] RAY_MIN = SUMW'(-(2 ** (DB - 1)));
  localparam logic [DNW-1:0] DELTA_NUM = DNW'({1'b1, {(2 * F){1'b0}}});
  localparam logic [QEW-1:0] DIST_MAX_X = QEW'({XB{1'b1}});
  localparam logic [F:0]     ONE_FX = {1'b1, {F{1'b0}}};

  // Configuration registers
  logic [PB-1:0]        pos_x_q, pos_y_q;
  logic signed [DB-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [CB-1:0]        width_q;
  logic [2:0]           reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rcrs_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite;

  // Register writes on the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      dir_x_q   <= DIR_X_RST;
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= PLANE_Y_RST;
      width_q   <= WIDTH_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rcrs_pkg::REG_POS_X:   pos_x_q   <= pwdata[PB-1:0];
        rcrs_pkg::REG_POS_Y:   pos_y_q   <= pwdata[PB-1:0];
        rcrs_pkg::REG_DIR_X:   dir_x_q   <= pwdata[DB-1:0];
        rcrs_pkg::REG_DIR_Y:   dir_y_q   <= pwdata[DB-1:0];
        rcrs_pkg::REG_PLANE_X: plane_x_q <= pwdata[DB-1:0];
        rcrs_pkg::REG_PLANE_Y: plane_y_q <= pwdata[DB-1:0];
        rcrs_pkg::REG_WIDTH:   width_q   <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      rcrs_pkg::REG_POS_X:   prdata = 32'(pos_x_q);
      rcrs_pkg::REG_POS_Y:   prdata = 32'(pos_y_q);
      rcrs_pkg::REG_DIR_X:   prdata = 32'(unsigned'(dir_x_q));
      rcrs_pkg::REG_DIR_Y:   prdata = 32'(unsigned'(dir_y_q));
      rcrs_pkg::REG_PLANE_X: prdata = 32'(unsigned'(plane_x_q));
      rcrs_pkg::REG_PLANE_Y: prdata = 32'(unsigned'(plane_y_q));
      rcrs_pkg::REG_WIDTH:   prdata = 32'(width_q);
      default:               prdata = '0;
    endcase
  end

  // Pipeline advance: everything moves unless a result waits at the output.
  logic           adv;
  logic [LAT-1:0] vld_q;
  logic [CB-1:0]  w_eff;

  assign adv         = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[LAT-1];
  assign w_eff       = (width_q == '0) ? CB'(1) : width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // Stages A to C: centred column numerator, plane product, magnitude.
  logic signed [NUMW-1:0]  num_a_q;
  logic signed [PRODW-1:0] prod_x_b_q, prod_y_b_q;
  logic signed [PRODW-1:0] abs_x, abs_y;
  logic [DNW-1:0]          mag_x_c_q, mag_y_c_q;
  logic                    neg_x_c_q, neg_y_c_q;

  assign abs_x = prod_x_b_q[PRODW-1] ? -prod_x_b_q : prod_x_b_q;
  assign abs_y = prod_y_b_q[PRODW-1] ? -prod_y_b_q : prod_y_b_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_a_q    <= {1'b0, column_i, 1'b0} - {2'b00, w_eff};
      prod_x_b_q <= plane_x_q * num_a_q;
      prod_y_b_q <= plane_y_q * num_a_q;
      neg_x_c_q  <= prod_x_b_q[PRODW-1];
      neg_y_c_q  <= prod_y_b_q[PRODW-1];
      mag_x_c_q  <= DNW'(unsigned'(abs_x));
      mag_y_c_q  <= DNW'(unsigned'(abs_y));
    end
  end

  // Division of the plane product by the screen width.
  logic [DNW-1:0] quo1_x, quo1_y;
  logic [DNW-1:0] neg_pipe_q [2];

  rcrs_div u_div_rx (
    .clk_i (clk_i), .en_i (adv), .num_i (mag_x_c_q), .den_i (DDW'(w_eff)), .quo_o (quo1_x)
  );
  rcrs_div u_div_ry (
    .clk_i (clk_i), .en_i (adv), .num_i (mag_y_c_q), .den_i (DDW'(w_eff)), .quo_o (quo1_y)
  );

  // Product signs travel alongside the divider stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg_pipe_q[0] <= {neg_pipe_q[0][DNW-2:0], neg_x_c_q};
      neg_pipe_q[1] <= {neg_pipe_q[1][DNW-2:0], neg_y_c_q};
    end
  end

  // Stage E: restore the sign, add the view direction and saturate.
  logic signed [DNW:0]    sq_x, sq_y;
  logic signed [SUMW-1:0] sum_x, sum_y;
  logic signed [DB-1:0]   ray_x_e_q, ray_y_e_q;

  assign sq_x  = neg_pipe_q[0][DNW-1] ? -signed'({1'b0, quo1_x}) : signed'({1'b0, quo1_x});
  assign sq_y  = neg_pipe_q[1][DNW-1] ? -signed'({1'b0, quo1_y}) : signed'({1'b0, quo1_y});
  assign sum_x = SUMW'(dir_x_q) + SUMW'(sq_x);
  assign sum_y = SUMW'(dir_y_q) + SUMW'(sq_y);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (sum_x > RAY_MAX) begin
        ray_x_e_q <= RAY_MAX[DB-1:0];
      end else if (sum_x < RAY_MIN) begin
        ray_x_e_q <= RAY_MIN[DB-1:0];
      end else begin
        ray_x_e_q <= sum_x[DB-1:0];
      end
      if (sum_y > RAY_MAX) begin
        ray_y_e_q <= RAY_MAX[DB-1:0];
      end else if (sum_y < RAY_MIN) begin
        ray_y_e_q <= RAY_MIN[DB-1:0];
      end else begin
        ray_y_e_q <= sum_y[DB-1:0];
      end
    end
  end

  // Stage F: ray magnitude and distance to the first grid line.
  logic [DB-1:0]        mag_x_f_q, mag_y_f_q;
  logic [F:0]           d_x_f_q, d_y_f_q;
  logic signed [DB-1:0] ray_x_f_q, ray_y_f_q;
  logic [F-1:0]         frac_x, frac_y;

  assign frac_x = pos_x_q[F-1:0];
  assign frac_y = pos_y_q[F-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ray_x_f_q <= ray_x_e_q;
      ray_y_f_q <= ray_y_e_q;
      mag_x_f_q <= ray_x_e_q[DB-1] ? unsigned'(-ray_x_e_q) : unsigned'(ray_x_e_q);
      mag_y_f_q <= ray_y_e_q[DB-1] ? unsigned'(-ray_y_e_q) : unsigned'(ray_y_e_q);
      d_x_f_q   <= ray_x_e_q[DB-1] ? {1'b0, frac_x} : ONE_FX - {1'b0, frac_x};
      d_y_f_q   <= ray_y_e_q[DB-1] ? {1'b0, frac_y} : ONE_FX - {1'b0, frac_y};
    end
  end

  // Reciprocal and side distance divisions.
  logic [DNW-1:0] dq_x, dq_y, sq_dx, sq_dy;

  rcrs_div u_div_dx (
    .clk_i (clk_i), .en_i (adv), .num_i (DELTA_NUM), .den_i (DDW'(mag_x_f_q)), .quo_o (dq_x)
  );
  rcrs_div u_div_dy (
    .clk_i (clk_i), .en_i (adv), .num_i (DELTA_NUM), .den_i (DDW'(mag_y_f_q)), .quo_o (dq_y)
  );
  rcrs_div u_div_sx (
    .clk_i (clk_i), .en_i (adv), .num_i (DNW'({d_x_f_q, {F{1'b0}}})),
    .den_i (DDW'(mag_x_f_q)), .quo_o (sq_dx)
  );
  rcrs_div u_div_sy (
    .clk_i (clk_i), .en_i (adv), .num_i (DNW'({d_y_f_q, {F{1'b0}}})),
    .den_i (DDW'(mag_y_f_q)), .quo_o (sq_dy)
  );

  // Ray directions travel alongside the distance dividers.
  logic signed [DB-1:0] ray_pipe_x_q [DNW];
  logic signed [DB-1:0] ray_pipe_y_q [DNW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ray_pipe_x_q[0] <= ray_x_f_q;
      ray_pipe_y_q[0] <= ray_y_f_q;
      for (int k = 1; k < DNW; k++) begin
        ray_pipe_x_q[k] <= ray_pipe_x_q[k-1];
        ray_pipe_y_q[k] <= ray_pipe_y_q[k-1];
      end
    end
  end

  // Output stage: saturate distances and form steps and cells.
  logic signed [DB-1:0] ray_x_z, ray_y_z;
  logic                 zero_x, zero_y;
  logic [QEW-1:0]       dqe_x, dqe_y, sqe_x, sqe_y;

  assign ray_x_z = ray_pipe_x_q[DNW-1];
  assign ray_y_z = ray_pipe_y_q[DNW-1];
  assign zero_x  = (ray_x_z == '0);
  assign zero_y  = (ray_y_z == '0);
  assign dqe_x   = QEW'(dq_x);
  assign dqe_y   = QEW'(dq_y);
  assign sqe_x   = QEW'(sq_dx);
  assign sqe_y   = QEW'(sq_dy);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ray_x_o      <= ray_x_z;
      ray_y_o      <= ray_y_z;
      cell_x_o     <= pos_x_q[PB-1:F];
      cell_y_o     <= pos_y_q[PB-1:F];
      step_dir_x_o <= ray_x_z[DB-1] ? rcrs_pkg::STEP_NEG : rcrs_pkg::STEP_POS;
      step_dir_y_o <= ray_y_z[DB-1] ? rcrs_pkg::STEP_NEG : rcrs_pkg::STEP_POS;
      delta_x_o    <= (zero_x || dqe_x > DIST_MAX_X) ? '1 : dqe_x[XB-1:0];
      delta_y_o    <= (zero_y || dqe_y > DIST_MAX_X) ? '1 : dqe_y[XB-1:0];
      side_x_o     <= (zero_x || sqe_x > DIST_MAX_X) ? '1 : sqe_x[XB-1:0];
      side_y_o     <= (zero_y || sqe_y > DIST_MAX_X) ? '1 : sqe_y[XB-1:0];
    end
  end

endmodule

@@ rtl/rcrs_chk.sv @@
// Port-level checker for the column ray setup block, bound to the top level.
module rcrs_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [rcrs_pkg::DIR_BITS-1:0] ray_x_o,
  input logic signed [rcrs_pkg::DIR_BITS-1:0] ray_y_o,
  input logic signed [1:0]                    step_dir_x_o,
  input logic signed [1:0]                    step_dir_y_o,
  input logic [rcrs_pkg::DIST_BITS-1:0]       delta_x_o,
  input logic [rcrs_pkg::DIST_BITS-1:0]       side_x_o
);

  // A stalled result transaction stays valid and holds its x ray and x delta distance.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ray_x_o) && $stable(delta_x_o))
    else $error("result changed while stalled");

  // The grid step follows the sign of the ray on both axes.
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((step_dir_x_o == rcrs_pkg::STEP_NEG) == ray_x_o[rcrs_pkg::DIR_BITS-1]) &&
      ((step_dir_y_o == rcrs_pkg::STEP_NEG) == ray_y_o[rcrs_pkg::DIR_BITS-1]))
    else $error("step direction disagrees with ray sign");

  // A zero x ray component gives saturated x distances.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ray_x_o == '0 |-> delta_x_o == '1 && side_x_o == '1)
    else $error("zero ray without saturated distances");

  // The pipeline takes no column while the output is stalled.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted during output stall");

endmodule

bind raycast_column_ray_setup rcrs_chk u_rcrs_chk (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the column ray setup block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint DIST_MAX = (64'd1 << rcrs_pkg::DIST_BITS) - 1;
  localparam longint DIR_MAX  = (64'sd1 <<< (rcrs_pkg::DIR_BITS - 1)) - 1;
  localparam longint DIR_MIN  = -(64'sd1 <<< (rcrs_pkg::DIR_BITS - 1));
  localparam longint ONE_FX   = 64'sd1 <<< rcrs_pkg::FRAC_BITS;

  typedef struct packed {
    logic signed [rcrs_pkg::DIR_BITS-1:0] ray_x;
    logic signed [rcrs_pkg::DIR_BITS-1:0] ray_y;
    logic [rcrs_pkg::CELL_BITS-1:0]       cell_x;
    logic [rcrs_pkg::CELL_BITS-1:0]       cell_y;
    logic signed [1:0]                    step_dir_x;
    logic signed [1:0]                    step_dir_y;
    logic [rcrs_pkg::DIST_BITS-1:0]       delta_x;
    logic [rcrs_pkg::DIST_BITS-1:0]       delta_y;
    logic [rcrs_pkg::DIST_BITS-1:0]       side_x;
    logic [rcrs_pkg::DIST_BITS-1:0]       side_y;
  } ray_setup_t;

  // Predicts each ray from the camera copy and checks results in order.
  class ray_scoreboard;
    longint pos_x, pos_y, dir_x, dir_y, plane_x, plane_y, width;
    ray_setup_t pending_rays[$];
    int failures;
    int checked;

    function void reset_camera();
      pos_x = 0; pos_y = 0; dir_x = 65536; dir_y = 0;
      plane_x = 0; plane_y = 43254; width = 640;
    endfunction

    function longint clamp_dir(longint v);
      if (v > DIR_MAX) return DIR_MAX;
      if (v < DIR_MIN) return DIR_MIN;
      return v;
    endfunction

    function longint sat_quot(longint n, longint d);
      longint q;
      if (d == 0) return (n == 0) ? 0 : DIST_MAX;
      q = n / d;
      return (q > DIST_MAX) ? DIST_MAX : q;
    endfunction

    // Works out one axis: step, delta and side distance from ray and position.
    function void axis_setup(input longint ray, input longint pos,
                             output logic signed [1:0] step,
                             output longint delta, output longint side);
      longint mag, frac, line_dist;
      mag  = (ray < 0) ? -ray : ray;
      frac = pos & (ONE_FX - 1);
      line_dist = (ray < 0) ? frac : ONE_FX - frac;
      step = (ray < 0) ? rcrs_pkg::STEP_NEG : rcrs_pkg::STEP_POS;
      delta = (mag == 0) ? DIST_MAX
                         : sat_quot(64'sd1 <<< (2 * rcrs_pkg::FRAC_BITS), mag);
      side = sat_quot(line_dist <<< rcrs_pkg::FRAC_BITS, mag);
    endfunction

    function void note_column(logic [rcrs_pkg::COLUMN_BITS-1:0] col);
      ray_setup_t e;
      longint w, num, rx, ry, dx, dy, sx, sy;
      w   = (width == 0) ? 1 : width;
      num = 2 * longint'(col) - w;
      rx  = clamp_dir(dir_x + (plane_x * num) / w);
      ry  = clamp_dir(dir_y + (plane_y * num) / w);
      e.ray_x  = rx[rcrs_pkg::DIR_BITS-1:0];
      e.ray_y  = ry[rcrs_pkg::DIR_BITS-1:0];
      e.cell_x = pos_x[rcrs_pkg::FRAC_BITS +: rcrs_pkg::CELL_BITS];
      e.cell_y = pos_y[rcrs_pkg::FRAC_BITS +: rcrs_pkg::CELL_BITS];
      axis_setup(rx, pos_x, e.step_dir_x, dx, sx);
      axis_setup(ry, pos_y, e.step_dir_y, dy, sy);
      e.delta_x = dx[rcrs_pkg::DIST_BITS-1:0];
      e.delta_y = dy[rcrs_pkg::DIST_BITS-1:0];
      e.side_x  = sx[rcrs_pkg::DIST_BITS-1:0];
      e.side_y  = sy[rcrs_pkg::DIST_BITS-1:0];
      pending_rays.push_back(e);
    endfunction

    function void cmp(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_result(ray_setup_t a);
      ray_setup_t e;
      if (pending_rays.size() == 0) begin
        $error("result arrived with no column outstanding");
        failures++;
        return;
      end
      e = pending_rays.pop_front();
      checked++;
      cmp("ray_x", e.ray_x, a.ray_x);
      cmp("ray_y", e.ray_y, a.ray_y);
      cmp("cell_x", e.cell_x, a.cell_x);
      cmp("cell_y", e.cell_y, a.cell_y);
      cmp("step_dir_x", e.step_dir_x, a.step_dir_x);
      cmp("step_dir_y", e.step_dir_y, a.step_dir_y);
      cmp("delta_x", e.delta_x, a.delta_x);
      cmp("delta_y", e.delta_y, a.delta_y);
      cmp("side_x", e.side_x, a.side_x);
      cmp("side_y", e.side_y, a.side_y);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [rcrs_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [rcrs_pkg::COLUMN_BITS-1:0] column_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  ray_setup_t got;

  ray_scoreboard sb = new();
  bit no_idle;
  bit long_hold_req;
  int sent;

  raycast_column_ray_setup dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .column_i, .out_valid_o, .out_ready_i,
    .ray_x_o(got.ray_x), .ray_y_o(got.ray_y), .cell_x_o(got.cell_x),
    .cell_y_o(got.cell_y), .step_dir_x_o(got.step_dir_x),
    .step_dir_y_o(got.step_dir_y), .delta_x_o(got.delta_x),
    .delta_y_o(got.delta_y), .side_x_o(got.side_x), .side_y_o(got.side_y)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 0;
        hold = 300;
      end else if (hold == 0) begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Results are checked at the edge where the transaction completes.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(got);
  end

  // Writes one camera register over APB and mirrors it in the scoreboard.
  task automatic write_reg(logic [2:0] idx, longint value);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = rcrs_pkg::ADDR_W'(idx) << 2;
    pwdata = 32'(value);
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      rcrs_pkg::REG_POS_X:
        sb.pos_x = value & ((64'd1 << rcrs_pkg::POS_BITS) - 1);
      rcrs_pkg::REG_POS_Y:
        sb.pos_y = value & ((64'd1 << rcrs_pkg::POS_BITS) - 1);
      rcrs_pkg::REG_DIR_X:
        sb.dir_x = longint'(signed'(value[rcrs_pkg::DIR_BITS-1:0]));
      rcrs_pkg::REG_DIR_Y:
        sb.dir_y = longint'(signed'(value[rcrs_pkg::DIR_BITS-1:0]));
      rcrs_pkg::REG_PLANE_X:
        sb.plane_x = longint'(signed'(value[rcrs_pkg::DIR_BITS-1:0]));
      rcrs_pkg::REG_PLANE_Y:
        sb.plane_y = longint'(signed'(value[rcrs_pkg::DIR_BITS-1:0]));
      default:
        sb.width = value & ((64'd1 << rcrs_pkg::COLUMN_BITS) - 1);
    endcase
  endtask

  task automatic set_camera(longint px, longint py, longint dx, longint dy,
                            longint plx, longint ply, longint w);
    write_reg(rcrs_pkg::REG_POS_X, px);
    write_reg(rcrs_pkg::REG_POS_Y, py);
    write_reg(rcrs_pkg::REG_DIR_X, dx);
    write_reg(rcrs_pkg::REG_DIR_Y, dy);
    write_reg(rcrs_pkg::REG_PLANE_X, plx);
    write_reg(rcrs_pkg::REG_PLANE_Y, ply);
    write_reg(rcrs_pkg::REG_WIDTH, w);
  endtask

  // Sends one column; valid stays high across back-to-back transactions.
  task automatic send_column(logic [rcrs_pkg::COLUMN_BITS-1:0] col);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    column_i = col;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_column(col);
    sent++;
  endtask

  // Lowers valid and waits for every outstanding result, then lets the pipeline idle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_rays.size() != 0) @(posedge clk_i);
    repeat (rcrs_pkg::LAT + 10) @(posedge clk_i);
  endtask

  function longint rand_dir();
    case ($urandom_range(0, 5))
      0: return DIR_MAX;
      1: return DIR_MIN;
      2: return 0;
      default: return longint'($urandom_range(0, (1 << rcrs_pkg::DIR_BITS) - 1));
    endcase
  endfunction

  function longint rand_pos();
    case ($urandom_range(0, 5))
      0: return (64'd1 << rcrs_pkg::POS_BITS) - 1;
      1: return 0;
      2: return longint'($urandom_range(0, 255)) << rcrs_pkg::FRAC_BITS;
      default: return longint'($urandom_range(0, (1 << rcrs_pkg::POS_BITS) - 1));
    endcase
  endfunction

  function logic [rcrs_pkg::COLUMN_BITS-1:0] rand_column(longint w);
    if ($urandom_range(0, 9) == 0) return rcrs_pkg::COLUMN_BITS'($urandom);
    return rcrs_pkg::COLUMN_BITS'($urandom_range(0, (w == 0) ? 0 : int'(w) - 1));
  endfunction

  initial begin
    longint w;
    sb.reset_camera();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset camera, the column extremes and a column past the width.
    send_column(0);
    send_column(rcrs_pkg::COLUMN_BITS'(320));
    send_column(rcrs_pkg::COLUMN_BITS'(639));
    send_column(rcrs_pkg::COLUMN_BITS'(640));
    send_column('1);
    drain();

    // Zero ray components on both axes, and a cell-aligned position.
    set_camera(64'h05_0000, 64'hff_ffff, 0, 0, 0, 0, 1);
    send_column(0);
    send_column(1);
    send_column('1);
    drain();

    // Saturating rays, negative rays on cell-aligned positions, width 4095.
    set_camera(64'h80_0000, 64'h00_0000, DIR_MAX, DIR_MIN, DIR_MAX, DIR_MIN,
               (1 << rcrs_pkg::COLUMN_BITS) - 1);
    send_column(0);
    send_column(rcrs_pkg::COLUMN_BITS'(2047));
    send_column('1);
    drain();
    write_reg(rcrs_pkg::REG_DIR_X, DIR_MIN);
    send_column(rcrs_pkg::COLUMN_BITS'(100));
    drain();
    set_camera(64'h00_0000, 64'h80_0000, DIR_MIN, 1, DIR_MIN, DIR_MAX, 0);
    send_column(0);
    send_column(1);
    send_column('1);
    send_column(rcrs_pkg::COLUMN_BITS'(1));
    drain();

    // Tiny ray magnitudes overflow the distances.
    set_camera(64'h12_3456, 64'hab_cdef, 1, -1, 0, 0, 2);
    send_column(0);
    send_column(1);
    send_column(2);
    drain();

    // Random cameras; one phase without idling, one with a long output hold.
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 4))
        0: w = 1;
        1: w = (1 << rcrs_pkg::COLUMN_BITS) - 1;
        2: w = $urandom_range(2, 64);
        default: w = $urandom_range(1, (1 << rcrs_pkg::COLUMN_BITS) - 1);
      endcase
      set_camera(rand_pos(), rand_pos(), rand_dir(), rand_dir(), rand_dir(),
                 rand_dir(), w);
      no_idle = (ph == 3);
      if (ph == 6) long_hold_req = 1;
      for (int i = 0; i < 123; i++) send_column(rand_column(w));
      no_idle = 0;
      drain();
    end

    $display("tb_top: %0d columns sent over 15 camera settings, %0d rays checked",
             sent, sb.checked);
    $display("tb_top: covered zero, saturated and tiny rays, widths 0 to 4095");
    if (sb.failures == 0 && sb.pending_rays.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule
